/* design/lbtd_pkg.sv */
// Package with the transaction types and command codes of the LED blink driver.
`timescale 1ns / 1ps

package lbtd_pkg;

	localparam logic [3:0] MODE_TICK          = 4'd0;
	localparam logic [3:0] MODE_ON            = 4'd1;
	localparam logic [3:0] MODE_ON_FOR        = 4'd2;
	localparam logic [3:0] MODE_OFF           = 4'd3;
	localparam logic [3:0] MODE_BLINK_DEFAULT = 4'd4;
	localparam logic [3:0] MODE_BLINK_RATE    = 4'd5;
	localparam logic [3:0] MODE_BLINK_COUNT   = 4'd6;
	localparam logic [3:0] MODE_TOGGLE        = 4'd7;
	localparam logic [3:0] MODE_SET_LEVEL     = 4'd8;

	localparam logic [15:0] DEFAULT_HALF_MS   = 16'd1000;
	localparam logic [15:0] ZERO_RATE_HALF_MS = 16'd500;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] duration;
		logic [15:0] half_period;
		logic [15:0] blink_count;
		logic        level;
	} cmd_item_t;

	typedef struct packed {
		logic pin_level;
		logic led_state;
		logic blink_active;
		logic timed_off_active;
	} rsp_item_t;

endpackage

/* design/lbtd_cmd_reg.sv */
// Input register stage that holds one accepted command transaction.
`timescale 1ns / 1ps

module lbtd_cmd_reg
	import lbtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	input  logic      advance,
	output logic      item_valid_s1,
	output cmd_item_t item_s1
);

	logic valid_s1;

	assign cmd_ready = !valid_s1 || advance;
	assign item_valid_s1 = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1 <= cmd;
		end
	end

endmodule

/* design/lbtd_core.sv */
// LED state registers and the single-pass update for commands and ticks.
`timescale 1ns / 1ps

module lbtd_core
	import lbtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  cmd_item_t item,
	output rsp_item_t result
);

	logic [31:0] now_q;
	logic [31:0] last_toggle_q;
	logic [31:0] deadline_q;
	logic [15:0] half_q;
	logic [17:0] toggles_q;
	logic        forever_q;
	logic        light_q;
	logic        driven_q;
	logic        blink_q;
	logic        timed_q;

	logic [31:0] now_n;
	logic [31:0] last_toggle_n;
	logic [31:0] deadline_n;
	logic [15:0] half_n;
	logic [17:0] toggles_n;
	logic        forever_n;
	logic        light_n;
	logic        driven_n;
	logic        blink_n;
	logic        timed_n;

	logic [15:0] half_in;
	logic [31:0] now_inc;
	logic [31:0] elapsed;

	assign half_in = (item.half_period == 16'd0) ? ZERO_RATE_HALF_MS : item.half_period;
	assign now_inc = now_q + 32'd1;
	assign elapsed = now_inc - last_toggle_q;

	always_comb begin
		now_n         = now_q;
		last_toggle_n = last_toggle_q;
		deadline_n    = deadline_q;
		half_n        = half_q;
		toggles_n     = toggles_q;
		forever_n     = forever_q;
		light_n       = light_q;
		driven_n      = driven_q;
		blink_n       = blink_q;
		timed_n       = timed_q;
		case (item.mode)
			MODE_TICK: begin
				now_n = now_inc;
				if (blink_q) begin
					if (elapsed >= {16'd0, half_q}) begin
						light_n       = !light_q;
						last_toggle_n = now_inc;
						if (!forever_q && toggles_q != 18'd0) begin
							toggles_n = toggles_q - 18'd1;
						end
					end
					if (!forever_q && toggles_n == 18'd0) begin
						blink_n = 1'b0;
					end
				end
				if (timed_q && now_inc >= deadline_q) begin
					light_n = 1'b0;
					timed_n = 1'b0;
				end
				driven_n = light_n;
			end
			MODE_ON: begin
				light_n = 1'b1;
				blink_n = 1'b0;
				timed_n = 1'b0;
			end
			MODE_ON_FOR: begin
				light_n    = 1'b1;
				blink_n    = 1'b0;
				timed_n    = 1'b1;
				deadline_n = now_q + item.duration;
			end
			MODE_OFF: begin
				light_n = 1'b0;
				blink_n = 1'b0;
				timed_n = 1'b0;
			end
			MODE_BLINK_DEFAULT: begin
				blink_n   = !blink_q;
				half_n    = DEFAULT_HALF_MS;
				forever_n = 1'b1;
				timed_n   = 1'b0;
			end
			MODE_BLINK_RATE: begin
				blink_n   = !blink_q;
				half_n    = half_in;
				forever_n = 1'b1;
				timed_n   = 1'b0;
			end
			MODE_BLINK_COUNT: begin
				blink_n   = !blink_q;
				half_n    = half_in;
				forever_n = 1'b0;
				toggles_n = {1'b0, item.blink_count, 1'b0};
				timed_n   = 1'b0;
			end
			MODE_TOGGLE: begin
				light_n = !light_q;
				blink_n = 1'b0;
				timed_n = 1'b0;
			end
			MODE_SET_LEVEL: begin
				light_n = item.level;
				blink_n = 1'b0;
				timed_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign result.pin_level        = driven_n;
	assign result.led_state        = light_n;
	assign result.blink_active     = blink_n;
	assign result.timed_off_active = timed_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			last_toggle_q <= '0;
			deadline_q    <= '0;
			half_q        <= '0;
			toggles_q     <= '0;
			forever_q     <= 1'b0;
			light_q       <= 1'b0;
			driven_q      <= 1'b0;
			blink_q       <= 1'b0;
			timed_q       <= 1'b0;
		end else if (fire) begin
			now_q         <= now_n;
			last_toggle_q <= last_toggle_n;
			deadline_q    <= deadline_n;
			half_q        <= half_n;
			toggles_q     <= toggles_n;
			forever_q     <= forever_n;
			light_q       <= light_n;
			driven_q      <= driven_n;
			blink_q       <= blink_n;
			timed_q       <= timed_n;
		end
	end

	a_pin_on_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode != MODE_TICK |=> driven_q == $past(driven_q))
		else $error("Pin level changed on a command transaction.");

	a_time_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.mode == MODE_TICK |=> now_q == $past(now_q) + 32'd1)
		else $error("Millisecond time did not advance on a tick.");

	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && item.mode == MODE_TICK) |=> now_q == $past(now_q))
		else $error("Millisecond time moved without a tick.");

	a_timed_arm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(timed_q) |-> $past(fire && item.mode == MODE_ON_FOR))
		else $error("Timed turn-off armed without an on_for command.");

endmodule

/* design/lbtd_rsp_reg.sv */
// Output register that holds one result transaction until the receiver takes it.
`timescale 1ns / 1ps

module lbtd_rsp_reg
	import lbtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rsp_item_t result,
	output logic      advance,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic      valid_q;
	rsp_item_t data_q;

	assign advance   = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

/* design/led_blink_timed_driver_unit.sv */
// Top level of the single LED driver with blinking and timed turn-off.
//
// Usage: commands and millisecond ticks arrive as transactions on the cmd
// channel (cmd_valid, cmd_ready, cmd); every transaction produces exactly one
// result transaction on the rsp channel (rsp_valid, rsp_ready, rsp), which
// reports the pin level, the logical LED state, the blink enable and whether
// a timed turn-off is pending, all taken after the transaction has applied.
// A tick transaction advances the internal millisecond time by one.
// A command passes through the input register and then the output register
// before rsp_valid rises. Throughput is one transaction per cycle while the
// receiver does not stall, set by the single update pass between the input
// register and the output register; the LED state registers close that loop.
// When the receiver stalls, the result stays in the output register, one
// further transaction waits in the input register, and cmd_ready then falls.
// Reset clears all LED state, the millisecond time and both channel valids.
`timescale 1ns / 1ps

module led_blink_timed_driver_unit
	import lbtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	logic      advance;
	logic      item_valid_s1;
	cmd_item_t item_s1;
	logic      fire;
	rsp_item_t result;

	assign fire = item_valid_s1 && advance;

	lbtd_cmd_reg u_cmd_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	lbtd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	lbtd_rsp_reg u_rsp_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.advance   (advance),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
